@@ hdl/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, prop, msg)
`define ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

@@ hdl/bfa_pkg.sv @@
// Package for the best-fit allocator: sizes, status codes, payload types.
// No dependencies.
package bfa_pkg;
  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int ADDR_W = 20;
  localparam int LEN_W = ADDR_W + 1;
  localparam int ENT_W = ADDR_W + LEN_W;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  typedef struct packed {
    logic opcode;
    logic [LEN_W-1:0] req_size;
    logic [ADDR_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [1:0] status;
    logic [LEN_W-1:0] freed_size;
  } rsp_t;

  // one region entry: base and length
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0] len;
  } ent_t;
endpackage

@@ hdl/best_fit_allocator_coalescing_core.sv @@
// Best-fit allocator with coalescing free list; tables in two RAMs.
// One request at a time (busy high while working); results are a one-cycle strobe.
// Synchronous reset sets up a pool of 65536 and each cfg_we write one of cfg_data,
// saturated at 1 << ADDR_W (counts and the first free-table entry); result
// receiver cannot stall.
`include "assert_macros.svh"
module best_fit_allocator_coalescing_core
  import bfa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  req_t                req,
  output logic                busy,
  input  logic                cfg_we,
  input  logic [LEN_W-1:0]    cfg_data,
  output logic                done,
  output rsp_t                rsp
);
  localparam logic [3:0] S_IDLE = 4'd0, S_AF_RD = 4'd1, S_AF_CMP = 4'd2,
    S_A_WR = 4'd3, S_SHL_RD = 4'd4, S_SHL_WR = 4'd5, S_U_RD = 4'd6,
    S_U_CMP = 4'd7, S_FP_RD = 4'd8, S_FP_CMP = 4'd9, S_FN_WAIT = 4'd10,
    S_F_DEC = 4'd11, S_SHR_RD = 4'd12, S_SHR_WR = 4'd13, S_UL_RD = 4'd14,
    S_DONE = 4'd15;

  logic [3:0] state;
  logic [CNT_W-1:0] free_count, used_count, idx;
  logic op;
  logic [LEN_W-1:0] rq;
  logic [ADDR_W-1:0] fa;
  logic found;
  logic [IDX_W-1:0] best;
  ent_t best_ent, prev_ent, next_ent;
  logic [LEN_W-1:0] ulen;
  logic [IDX_W-1:0] uidx;
  logic [CNT_W-1:0] pos;
  logic has_prev;
  logic [1:0] st;
  logic [ADDR_W-1:0] raddr_out;
  logic rm_after;

  logic f_we, u_we;
  logic [IDX_W-1:0] f_wa, f_ra, u_wa, u_ra;
  ent_t f_wd, f_rd, u_wd, u_rd;

  bfa_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_free (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  bfa_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_used (
    .clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(u_ra), .rdata(u_rd));

  assign busy = (state != S_IDLE);

  logic [LEN_W-1:0] cfg_sat;
  assign cfg_sat = (cfg_data > LEN_W'(1 << ADDR_W)) ? LEN_W'(1 << ADDR_W) : cfg_data;

  // read address follows the scan index; the upward shift reads one slot below, the last-used read the top used slot
  always_comb begin
    f_ra = idx[IDX_W-1:0];
    u_ra = idx[IDX_W-1:0];
    if (state == S_SHR_RD) f_ra = IDX_W'(idx - 1'b1);
    if (state == S_UL_RD) u_ra = IDX_W'(used_count - 1'b1);
  end

  always_ff @(posedge clk) begin
    f_we <= 1'b0;
    u_we <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      free_count <= CNT_W'(1);
      used_count <= '0;
      f_we <= 1'b1;
      f_wa <= '0;
      f_wd <= '{base: '0, len: LEN_W'(65536)};
    end else if (cfg_we) begin
      free_count <= (cfg_sat == '0) ? '0 : CNT_W'(1);
      used_count <= '0;
      f_we <= 1'b1;
      f_wa <= '0;
      f_wd <= '{base: '0, len: cfg_sat};
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= req.opcode;
            rq <= req.req_size;
            fa <= req.free_addr;
            idx <= '0;
            found <= 1'b0;
            raddr_out <= '0;
            if (req.opcode == OP_ALLOC) begin
              if (req.req_size == '0) begin
                st <= ST_NOFIT;
                state <= S_DONE;
              end else begin
                state <= S_AF_RD;
              end
            end else begin
              state <= S_U_RD;
            end
          end
        end
        // best-fit scan: read then compare
        S_AF_RD: begin
          if (idx >= free_count) begin
            if (!found) begin
              st <= ST_NOFIT; state <= S_DONE;
            end else if (used_count >= CNT_W'(SLOTS)) begin
              st <= ST_FULL; state <= S_DONE;
            end else begin
              state <= S_A_WR;
            end
          end else begin
            state <= S_AF_CMP;
          end
        end
        S_AF_CMP: begin
          if (f_rd.len >= rq && (!found || f_rd.len < best_ent.len)) begin
            found <= 1'b1;
            best <= idx[IDX_W-1:0];
            best_ent <= f_rd;
          end
          idx <= idx + 1'b1;
          state <= S_AF_RD;
        end
        // record used region and carve the free one
        S_A_WR: begin
          u_we <= 1'b1;
          u_wa <= used_count[IDX_W-1:0];
          u_wd <= '{base: best_ent.base, len: rq};
          used_count <= used_count + 1'b1;
          raddr_out <= best_ent.base;
          st <= ST_OK;
          if (best_ent.len == rq) begin
            idx <= CNT_W'(best) + 1'b1;
            state <= S_SHL_RD;
          end else begin
            f_we <= 1'b1;
            f_wa <= best;
            f_wd <= '{base: best_ent.base + rq[ADDR_W-1:0], len: best_ent.len - rq};
            state <= S_DONE;
          end
        end
        // delete: shift entries down one slot
        S_SHL_RD: begin
          if (idx >= free_count) begin
            free_count <= free_count - 1'b1;
            state <= (op == OP_FREE) ? S_UL_RD : S_DONE;
          end else begin
            state <= S_SHL_WR;
          end
        end
        S_SHL_WR: begin
          f_we <= 1'b1;
          f_wa <= IDX_W'(idx - 1'b1);
          f_wd <= f_rd;
          idx <= idx + 1'b1;
          state <= S_SHL_RD;
        end
        // free: look up used table
        S_U_RD: begin
          if (idx >= used_count) begin
            st <= ST_UNKNOWN; state <= S_DONE;
          end else begin
            state <= S_U_CMP;
          end
        end
        S_U_CMP: begin
          if (u_rd.base == fa) begin
            uidx <= idx[IDX_W-1:0];
            ulen <= u_rd.len;
            idx <= '0;
            has_prev <= 1'b0;
            state <= S_FP_RD;
          end else begin
            idx <= idx + 1'b1;
            state <= S_U_RD;
          end
        end
        // find insertion point; remember predecessor
        S_FP_RD: begin
          if (idx >= free_count) begin
            pos <= idx;
            state <= S_F_DEC;
          end else begin
            state <= S_FP_CMP;
          end
        end
        S_FP_CMP: begin
          if (f_rd.base < fa) begin
            prev_ent <= f_rd;
            has_prev <= 1'b1;
            idx <= idx + 1'b1;
            state <= S_FP_RD;
          end else begin
            pos <= idx;
            next_ent <= f_rd;
            state <= S_FN_WAIT;
          end
        end
        S_FN_WAIT: state <= S_F_DEC;
        // merge decision
        S_F_DEC: begin
          logic jp, jn;
          logic [ADDR_W:0] pend, nend;
          pend = {1'b0, prev_ent.base} + prev_ent.len;
          nend = {1'b0, fa} + ulen;
          jp = has_prev && (pend == {1'b0, fa});
          jn = (pos < free_count) && (nend == {1'b0, next_ent.base});
          if (jp && jn) begin
            st <= ST_OK;
            f_we <= 1'b1;
            f_wa <= IDX_W'(pos - 1'b1);
            f_wd <= '{base: prev_ent.base, len: prev_ent.len + ulen + next_ent.len};
            idx <= pos + 1'b1;
            state <= S_SHL_RD;
          end else if (jp) begin
            st <= ST_OK;
            f_we <= 1'b1;
            f_wa <= IDX_W'(pos - 1'b1);
            f_wd <= '{base: prev_ent.base, len: prev_ent.len + ulen};
            state <= S_UL_RD;
          end else if (jn) begin
            st <= ST_OK;
            f_we <= 1'b1;
            f_wa <= pos[IDX_W-1:0];
            f_wd <= '{base: fa, len: next_ent.len + ulen};
            state <= S_UL_RD;
          end else if (free_count >= CNT_W'(SLOTS)) begin
            st <= ST_FULL;
            state <= S_DONE;
          end else begin
            st <= ST_OK;
            idx <= free_count;
            state <= S_SHR_RD;
          end
        end
        // insert: shift entries up from the top
        S_SHR_RD: begin
          if (idx == pos) begin
            f_we <= 1'b1;
            f_wa <= pos[IDX_W-1:0];
            f_wd <= '{base: fa, len: ulen};
            free_count <= free_count + 1'b1;
            state <= S_UL_RD;
          end else begin
            idx <= idx - 1'b1;
            state <= S_SHR_WR;
          end
        end
        S_SHR_WR: begin
          f_we <= 1'b1;
          f_wa <= IDX_W'(idx + 1'b1);
          f_wd <= f_rd;
          state <= S_SHR_RD;
        end
        // move last used entry into the hole
        S_UL_RD: begin
          if (rm_after) begin
            u_we <= 1'b1;
            u_wa <= uidx;
            u_wd <= u_rd;
            used_count <= used_count - 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          rsp.result_addr <= (st == ST_OK && op == OP_ALLOC) ? raddr_out : '0;
          rsp.status <= st;
          rsp.freed_size <= (st == ST_OK && op == OP_FREE) ? ulen : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the last-used read is registered; rm_after marks when its data is valid
  always_ff @(posedge clk) begin
    if (rst) rm_after <= 1'b0;
    else rm_after <= (state == S_UL_RD) && !rm_after;
  end

  `ASSERT_IMPL(a_cnt_free, clk, rst, free_count <= CNT_W'(SLOTS), "free count overflow")
  `ASSERT_IMPL(a_cnt_used, clk, rst, used_count <= CNT_W'(SLOTS), "used count overflow")
  `ASSERT_IMPL(a_done_idle, clk, rst, done |-> state == S_IDLE, "result outside idle")
  `ASSERT_IMPL(a_start_busy, clk, rst, (start && !busy && !cfg_we) |=> busy, "start not taken")
endmodule

@@ hdl/bfa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ verif/best_fit_allocator_coalescing_core_test.sv @@
// Testbench for the best-fit allocator core: directed and random alloc/free traffic.
// Depends on bfa_pkg and best_fit_allocator_coalescing_core; self-checking against
// an internal model of the region tables.
`timescale 1ns / 100ps
module best_fit_allocator_coalescing_core_test;
  import bfa_pkg::*;

  localparam int POOL_MAX = 1 << ADDR_W;

  logic clk;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic cfg_we;
  logic [LEN_W-1:0] cfg_data;
  logic done;
  rsp_t rsp;

  best_fit_allocator_coalescing_core dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .rsp(rsp)
  );

  // model state
  logic [LEN_W-1:0] pool_bytes;
  logic [ADDR_W-1:0] hole_base[SLOTS];
  logic [LEN_W-1:0] hole_len[SLOTS];
  int hole_cnt;
  logic [ADDR_W-1:0] owned_base[SLOTS];
  logic [LEN_W-1:0] owned_len[SLOTS];
  int owned_cnt;

  rsp_t pending_rsp[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int n_alloc_ok = 0, n_free_ok = 0, n_nofit = 0, n_full = 0, n_unknown = 0;
  bit quiet = 0;

  // free-running clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rebuild the tables for a new pool size
  function automatic void pool_setup(logic [LEN_W-1:0] size);
    pool_bytes = (size > POOL_MAX) ? LEN_W'(POOL_MAX) : size;
    owned_cnt = 0;
    hole_cnt = (pool_bytes == 0) ? 0 : 1;
    hole_base[0] = '0;
    hole_len[0] = pool_bytes;
  endfunction

  function automatic void hole_drop(int k);
    for (int i = k; i + 1 < hole_cnt; i++) begin
      hole_base[i] = hole_base[i + 1];
      hole_len[i] = hole_len[i + 1];
    end
    hole_cnt--;
  endfunction

  // work out the response of one request and update the tables
  function automatic rsp_t alloc_predict(req_t r);
    rsp_t o;
    int best, pos, u;
    logic [LEN_W-1:0] len;
    bit found, jp, jn;
    o = '0;
    best = 0;
    found = 0;
    if (r.opcode == OP_ALLOC) begin
      o.status = ST_NOFIT;
      if (r.req_size != 0) begin
        for (int i = 0; i < hole_cnt; i++)
          if (hole_len[i] >= r.req_size && (!found || hole_len[i] < hole_len[best])) begin
            best = i;
            found = 1;
          end
        if (found && owned_cnt >= SLOTS) o.status = ST_FULL;
        else if (found) begin
          o.status = ST_OK;
          o.result_addr = hole_base[best];
          owned_base[owned_cnt] = hole_base[best];
          owned_len[owned_cnt] = r.req_size;
          owned_cnt++;
          hole_base[best] += ADDR_W'(r.req_size);
          hole_len[best] -= r.req_size;
          if (hole_len[best] == 0) hole_drop(best);
        end
      end
      if (o.status == ST_OK) n_alloc_ok++;
      else if (o.status == ST_FULL) n_full++;
      else n_nofit++;
      return o;
    end
    u = 0;
    while (u < owned_cnt && owned_base[u] != r.free_addr) u++;
    if (u >= owned_cnt) begin
      o.status = ST_UNKNOWN;
      n_unknown++;
      return o;
    end
    len = owned_len[u];
    pos = 0;
    while (pos < hole_cnt && hole_base[pos] < r.free_addr) pos++;
    jp = pos > 0 && ({1'b0, hole_base[pos-1]} + hole_len[pos-1] == {1'b0, r.free_addr});
    jn = pos < hole_cnt && ({1'b0, r.free_addr} + len == {1'b0, hole_base[pos]});
    if (jp && jn) begin
      hole_len[pos-1] += len + hole_len[pos];
      hole_drop(pos);
    end else if (jp) begin
      hole_len[pos-1] += len;
    end else if (jn) begin
      hole_base[pos] = r.free_addr;
      hole_len[pos] += len;
    end else begin
      if (hole_cnt >= SLOTS) begin
        o.status = ST_FULL;
        n_full++;
        return o;
      end
      for (int i = hole_cnt; i > pos; i--) begin
        hole_base[i] = hole_base[i-1];
        hole_len[i] = hole_len[i-1];
      end
      hole_base[pos] = r.free_addr;
      hole_len[pos] = len;
      hole_cnt++;
    end
    owned_cnt--;
    owned_base[u] = owned_base[owned_cnt];
    owned_len[u] = owned_len[owned_cnt];
    o.status = ST_OK;
    o.freed_size = len;
    n_free_ok++;
    return o;
  endfunction

  // check each response against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      rsp_t exp_r;
      if (pending_rsp.size() == 0) begin
        $error("unexpected response addr=%0h status=%0d", rsp.result_addr, rsp.status);
        errors++;
      end else begin
        exp_r = pending_rsp.pop_front();
        checked++;
        if (rsp.result_addr !== exp_r.result_addr) begin
          $error("result_addr expected %0h actual %0h", exp_r.result_addr, rsp.result_addr);
          errors++;
        end
        if (rsp.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, rsp.status);
          errors++;
        end
        if (rsp.freed_size !== exp_r.freed_size) begin
          $error("freed_size expected %0h actual %0h", exp_r.freed_size, rsp.freed_size);
          errors++;
        end
      end
    end
  end

  // send one request; transfer happens at the edge with start high and busy low
  task automatic send_req(logic op, logic [LEN_W-1:0] size, logic [ADDR_W-1:0] addr);
    req_t r;
    @(negedge clk);
    if (!quiet)
      while ($urandom_range(99) < 25) @(negedge clk);
    r.opcode = op;
    r.req_size = size;
    r.free_addr = addr;
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp.push_back(alloc_predict(r));
    sent++;
    @(negedge clk);
    start <= 1'b0;
    req <= req_t'($urandom());
  endtask

  task automatic drain();
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_pool(logic [LEN_W-1:0] size);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= size;
    @(negedge clk);
    cfg_we <= 1'b0;
    pool_setup(size);
  endtask

  function automatic logic [ADDR_W-1:0] some_owned();
    if (owned_cnt == 0) return '0;
    return owned_base[$urandom_range(owned_cnt - 1)];
  endfunction

  // field extremes, each status, merges on both sides
  task automatic test_directed();
    logic [ADDR_W-1:0] a, b, c;
    send_req(OP_ALLOC, '0, '1);               // zero size
    send_req(OP_ALLOC, 21'h1FFFFF, '0);       // too big
    send_req(OP_FREE, 21'h1FFFFF, 20'hFFFFF); // unknown address
    send_req(OP_ALLOC, 100, 0);
    send_req(OP_ALLOC, 200, 0);
    send_req(OP_ALLOC, 300, 0);
    a = 0; b = 100; c = 300;
    send_req(OP_FREE, 0, b);                  // isolated hole
    send_req(OP_FREE, 0, a);                  // merge with next
    send_req(OP_FREE, 0, c);                  // merge both sides
    send_req(OP_ALLOC, 65536, 0);             // whole pool
    send_req(OP_FREE, 0, 0);
    drain();
    // sixteen allocations fill the used table, the next fails full
    for (int i = 0; i < SLOTS + 1; i++) send_req(OP_ALLOC, 1, 0);
    // free every other one; each becomes an isolated hole
    for (int i = 0; i < SLOTS; i += 2) send_req(OP_FREE, 0, ADDR_W'(i));
  endtask

  // small pools: many small isolated frees, then merges with the next hole and on both sides
  task automatic test_hole_table_full();
    write_pool(64);
    for (int i = 0; i < SLOTS; i++) send_req(OP_ALLOC, 2, 0);
    for (int i = 0; i < SLOTS; i += 2) send_req(OP_FREE, 0, ADDR_W'(2 * i));
    drain();
    write_pool(34);
    for (int i = 0; i < SLOTS; i++) send_req(OP_ALLOC, 2, 0);
    send_req(OP_FREE, 0, 30);
    for (int i = 0; i < SLOTS; i += 2) send_req(OP_FREE, 0, ADDR_W'(2 * i));
    send_req(OP_FREE, 0, 2);
  endtask

  // random traffic, mostly well-formed allocations and frees of owned regions
  task automatic test_random(int count, logic [LEN_W-1:0] pool, int max_req);
    logic [LEN_W-1:0] sz;
    write_pool(pool);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      quiet = (i % 200) < 60;
      case ($urandom_range(9))
        0: send_req(OP_FREE, LEN_W'($urandom()), ADDR_W'($urandom()));
        1: send_req(OP_ALLOC, LEN_W'($urandom()), ADDR_W'($urandom()));
        2, 3, 4, 5: begin
          sz = LEN_W'($urandom_range(max_req, 1));
          send_req(OP_ALLOC, sz, ADDR_W'($urandom()));
        end
        default: send_req(OP_FREE, LEN_W'($urandom()), some_owned());
      endcase
    end
    quiet = 0;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    pool_setup(65536);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_hole_table_full();
    write_pool(0);
    send_req(OP_ALLOC, 1, 0);
    send_req(OP_FREE, 0, 0);
    write_pool(21'h1FFFFF);                   // saturates
    send_req(OP_ALLOC, 21'h100000, 0);
    send_req(OP_ALLOC, 1, 0);
    send_req(OP_FREE, 0, 0);
    write_pool(1);
    send_req(OP_ALLOC, 1, 0);
    send_req(OP_FREE, 0, 0);
    test_random(500, 256, 40);
    test_random(500, 65536, 8000);
    test_random(300, 21'h100000, 200000);
    test_random(100, 21'h100000, 1048576);
    drain();
    $display("Sent %0d requests, checked %0d responses: %0d alloc ok, %0d free ok,",
             sent, checked, n_alloc_ok, n_free_ok);
    $display("  %0d no-fit, %0d table-full, %0d unknown-address.", n_nofit, n_full, n_unknown);
    if (errors == 0 && pending_rsp.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

@@ best_fit_allocator_coalescing_core.f @@
+incdir+hdl
hdl/bfa_pkg.sv
hdl/bfa_ram.sv
hdl/best_fit_allocator_coalescing_core.sv
verif/best_fit_allocator_coalescing_core_test.sv
